// ===== rtl/core/lbcw_pkg.sv =====
// Shared types and constants for the lzop block chain walker.
package lbcw_pkg;

  localparam int unsigned WordBytes = 4;

  // Configuration register indexes
  localparam logic REG_CHECKSUM_SELECT = 1'b0;
  localparam logic REG_MAX_TOTAL       = 1'b1;

  localparam logic [3:0]  CHECKSUM_SELECT_RESET = 4'h0;
  localparam logic [47:0] MAX_TOTAL_RESET       = 48'h0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] stream_length;
    logic [31:0] block_count;
    logic [47:0] total_uncompressed;
  } result_t;

endpackage

// ===== rtl/core/lbcw_walker.sv =====
// Block chain walk state and its per-byte next-state logic.
module lbcw_walker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  first_byte,
  input  logic                  last_byte,
  input  logic [3:0]            checksum_select,
  input  logic [47:0]           max_total,
  output logic                  res_valid,
  output lbcw_pkg::result_t     res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_PLAIN, PH_PACKED, PH_CHECK, PH_PAYLOAD, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  field_byte_index, field_byte_index_next;
  logic [31:0] plain_length, plain_length_next;
  logic [31:0] packed_length, packed_length_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [31:0] bytes_consumed, bytes_consumed_next;
  logic [47:0] uncompressed_sum, uncompressed_sum_next;
  logic [31:0] blocks_seen, blocks_seen_next;
  logic        emit;
  lbcw_pkg::status_t emit_status;

  always_comb begin
    logic [4:0]  cs;
    logic [48:0] sum_wide;
    logic [31:0] skip_dec;
    phase_t      ph;

    cs       = '0;
    sum_wide = '0;
    skip_dec = '0;
    ph       = first_byte ? PH_PLAIN : phase;

    phase_next            = ph;
    field_byte_index_next = first_byte ? 2'd0 : field_byte_index;
    plain_length_next     = first_byte ? '0 : plain_length;
    packed_length_next    = first_byte ? '0 : packed_length;
    skip_remaining_next   = first_byte ? '0 : skip_remaining;
    bytes_consumed_next   = first_byte ? '0 : bytes_consumed;
    uncompressed_sum_next = first_byte ? '0 : uncompressed_sum;
    blocks_seen_next      = first_byte ? '0 : blocks_seen;
    emit                  = 1'b0;
    emit_status           = lbcw_pkg::ST_TRUNC;

    if (ph != PH_IDLE && ph != PH_DONE) begin
      if (bytes_consumed_next != 32'hFFFF_FFFF) begin
        bytes_consumed_next = bytes_consumed_next + 32'd1;
      end
      skip_dec = (skip_remaining_next != '0) ? skip_remaining_next - 32'd1 : '0;

      unique case (ph)
        PH_PLAIN: begin
          plain_length_next = {plain_length_next[23:0], data_byte};
          if (field_byte_index_next == 2'd3) begin
            field_byte_index_next = 2'd0;
            if (plain_length_next == '0) begin
              // End marker: judge the whole stream
              emit = 1'b1;
              emit_status = (blocks_seen_next != '0 && uncompressed_sum_next != '0 &&
                             uncompressed_sum_next <= max_total)
                            ? lbcw_pkg::ST_VALID : lbcw_pkg::ST_INVALID;
            end else begin
              phase_next         = PH_PACKED;
              packed_length_next = '0;
            end
          end else begin
            field_byte_index_next = field_byte_index_next + 2'd1;
          end
        end
        PH_PACKED: begin
          packed_length_next = {packed_length_next[23:0], data_byte};
          if (field_byte_index_next == 2'd3) begin
            field_byte_index_next = 2'd0;
            if (packed_length_next == '0 || packed_length_next > plain_length_next) begin
              emit = 1'b1;
              emit_status = lbcw_pkg::ST_TRUNC;
            end else begin
              cs = 5'(lbcw_pkg::WordBytes) *
                   (5'(checksum_select[0]) + 5'(checksum_select[1]) +
                    ((packed_length_next < plain_length_next)
                     ? 5'(checksum_select[2]) + 5'(checksum_select[3]) : 5'd0));
              if (cs != '0) begin
                phase_next          = PH_CHECK;
                skip_remaining_next = 32'(cs);
              end else begin
                phase_next          = PH_PAYLOAD;
                skip_remaining_next = packed_length_next;
              end
            end
          end else begin
            field_byte_index_next = field_byte_index_next + 2'd1;
          end
        end
        PH_CHECK: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next          = PH_PAYLOAD;
            skip_remaining_next = packed_length_next;
          end
        end
        default: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            // Block complete
            sum_wide = {1'b0, uncompressed_sum_next} + {17'd0, plain_length_next};
            uncompressed_sum_next = sum_wide[48] ? 48'hFFFF_FFFF_FFFF : sum_wide[47:0];
            if (blocks_seen_next != 32'hFFFF_FFFF) begin
              blocks_seen_next = blocks_seen_next + 32'd1;
            end
            phase_next            = PH_PLAIN;
            field_byte_index_next = 2'd0;
            plain_length_next     = '0;
          end
        end
      endcase

      if (!emit && last_byte) begin
        emit = 1'b1;
        emit_status = lbcw_pkg::ST_TRUNC;
      end
      if (emit) begin
        phase_next = PH_DONE;
      end
    end
  end

  assign res_valid                  = take && emit;
  assign res.status                 = emit_status;
  assign res.stream_length          = bytes_consumed_next;
  assign res.block_count            = blocks_seen_next;
  assign res.total_uncompressed     = uncompressed_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      field_byte_index <= '0;
      plain_length     <= '0;
      packed_length    <= '0;
      skip_remaining   <= '0;
      bytes_consumed   <= '0;
      uncompressed_sum <= '0;
      blocks_seen      <= '0;
    end else if (take) begin
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      plain_length     <= plain_length_next;
      packed_length    <= packed_length_next;
      skip_remaining   <= skip_remaining_next;
      bytes_consumed   <= bytes_consumed_next;
      uncompressed_sum <= uncompressed_sum_next;
      blocks_seen      <= blocks_seen_next;
    end
  end

  // A result always closes the walk
  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == PH_DONE)
    else $error("walk not closed after result");

  // No result from a closed or idle walk unless restarted
  a_quiet_when_closed: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE || phase == PH_IDLE) && !first_byte |-> !res_valid)
    else $error("result from closed walk");

  // Checksum skip counts never exceed four words
  a_check_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHECK |-> skip_remaining <= 32'd16)
    else $error("checksum skip out of range");

endmodule

// ===== rtl/core/lbcw_out_reg.sv =====
// Output register holding one finished result until it is taken.
module lbcw_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lbcw_pkg::result_t load_res,
  input  logic              out_ready,
  output logic              out_valid,
  output lbcw_pkg::result_t out_res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// ===== rtl/core/lzop_block_chain_walker.sv =====
// Top level of the lzop block chain walker: config registers, walker, output stage.
//
// Walks the block chain of an lzop stream one byte per item, starting at the
// byte flagged first_byte. Each block's big-endian uncompressed and compressed
// lengths are read, the enabled checksum words (packed ones only for a block
// that is really compressed) and the payload are skipped, and complete blocks
// and their uncompressed bytes are counted with saturation. One result item
// comes out per walk: on the end marker (status 0 valid or 1 invalid), on a bad
// compressed length, or on a last_byte that does not end the walk (status 2).
// Bytes outside a walk are taken and dropped. Rate: one item per clock; the
// byte's state update is combinational logic (a 32-bit skip decrement and a
// 48-bit saturating add/compare) feeding the walk registers, and a result lands
// in an output register, so in_ready only drops when that register is full and
// out_ready is low. out_valid rises in the cycle after the ending byte is taken.
// checksum_select and max_total are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
module lzop_block_chain_walker (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  // byte items in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  // result items out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] stream_length,
  output logic [31:0] block_count,
  output logic [47:0] total_uncompressed
);

  logic [3:0]        checksum_select;
  logic [47:0]       max_total;
  logic              take;
  logic              res_valid;
  lbcw_pkg::result_t res;
  lbcw_pkg::result_t out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_select <= lbcw_pkg::CHECKSUM_SELECT_RESET;
      max_total       <= lbcw_pkg::MAX_TOTAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lbcw_pkg::REG_CHECKSUM_SELECT: checksum_select <= cfg_data[3:0];
        lbcw_pkg::REG_MAX_TOTAL:       max_total       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the output register has room for a possible result
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  lbcw_walker u_walker (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .data_byte       (data_byte),
    .first_byte      (first_byte),
    .last_byte       (last_byte),
    .checksum_select (checksum_select),
    .max_total       (max_total),
    .res_valid       (res_valid),
    .res             (res)
  );

  lbcw_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign status             = out_res.status;
  assign stream_length      = out_res.stream_length;
  assign block_count        = out_res.block_count;
  assign total_uncompressed = out_res.total_uncompressed;

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  // Every result covers at least the byte that ended the walk
  a_nonzero_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stream_length != 32'd0)
    else $error("result with zero stream length");

  // A stream with no complete block is never valid
  a_valid_needs_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_count == 32'd0 |-> status != lbcw_pkg::ST_VALID)
    else $error("valid status without blocks");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the lzop block chain walker: directed table, then random walks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Walk phases of the predictor, in the order a block is read.
  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_PLAIN,
    WALK_PACKED,
    WALK_CHECK,
    WALK_PAYLOAD,
    WALK_DONE
  } walk_state_t;

  // One row of the directed table. typed rows carry their result by hand.
  typedef struct packed {
    logic [7:0]        data;
    logic              first_flag;
    logic              last_flag;
    logic              typed;
    lbcw_pkg::result_t want;
  } row_t;

  localparam lbcw_pkg::result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [47:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  status;
  logic [31:0] stream_length;
  logic [31:0] block_count;
  logic [47:0] total_uncompressed;

  lzop_block_chain_walker dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .data_byte          (data_byte),
    .first_byte         (first_byte),
    .last_byte          (last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .stream_length      (stream_length),
    .block_count        (block_count),
    .total_uncompressed (total_uncompressed)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers
  logic [3:0]  cfg_cksel = lbcw_pkg::CHECKSUM_SELECT_RESET;
  logic [47:0] cfg_max = lbcw_pkg::MAX_TOTAL_RESET;

  // Predictor copy of the walk state
  walk_state_t walk_state = WALK_IDLE;
  logic [1:0]  len_byte_idx = '0;
  logic [31:0] plain_len = '0;
  logic [31:0] pk_len = '0;
  logic [31:0] skip_left = '0;
  logic [31:0] consumed = '0;
  logic [47:0] usum = '0;
  logic [31:0] nblocks = '0;

  lbcw_pkg::result_t expected_results [$];
  int unsigned mismatches = 0;
  int unsigned send_gap_pct = 0;    // chance (of 100) of an idle cycle before an item
  int unsigned stall_pct = 0;       // chance (of 100) that out_ready is low
  int unsigned items_in_phase;

  // Directed table, reset config (no checksums, limit 0xFFFFFFFF).
  row_t directed_rows [$] = '{
    // stray byte before any walk: dropped, even with last set
    {8'hFF, 1'b0, 1'b1, 1'b0, NO_RESULT},
    // walk cut short by a new first byte: no result for it
    {8'hFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
    {8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
    // plain 1, packed 2: packed above plain fails on its 4th byte
    {8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h02, 1'b0, 1'b0, 1'b1, lbcw_pkg::ST_TRUNC, 32'd8, 32'd0, 48'd0},
    // byte after an ended walk: dropped
    {8'h55, 1'b0, 1'b1, 1'b0, NO_RESULT},
    // one block of 1 byte, then the end marker: valid
    {8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'hAA, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b1, lbcw_pkg::ST_VALID, 32'd13, 32'd1, 48'd1},
    // empty chain, marker on the last byte: ended but invalid
    {8'h00, 1'b1, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
    {8'h00, 1'b0, 1'b1, 1'b1, lbcw_pkg::ST_INVALID, 32'd4, 32'd0, 48'd0}
  };

  // Bytes of checksum words that follow a block's two length fields.
  function automatic int unsigned checksum_span(input logic [3:0] sel,
                                                input logic [31:0] plain, pk);
    int unsigned n;
    n = 0;
    if (sel[0]) n += lbcw_pkg::WordBytes;
    if (sel[1]) n += lbcw_pkg::WordBytes;
    // packed checksums only for a block that really shrank
    if (pk < plain) begin
      if (sel[2]) n += lbcw_pkg::WordBytes;
      if (sel[3]) n += lbcw_pkg::WordBytes;
    end
    return n;
  endfunction

  // Advance the predicted walk by one accepted byte; got marks a result.
  task automatic walk_step(input logic [7:0] b, input logic f, l,
                           output bit got, output lbcw_pkg::result_t r);
    logic [48:0]       sum_next;
    lbcw_pkg::status_t st;
    bit                ended;
    got = 1'b0;
    r = '0;
    ended = 1'b0;
    st = lbcw_pkg::ST_TRUNC;
    if (f) begin
      walk_state = WALK_PLAIN;
      len_byte_idx = '0;
      plain_len = '0;
      pk_len = '0;
      skip_left = '0;
      consumed = '0;
      usum = '0;
      nblocks = '0;
    end
    if (walk_state == WALK_IDLE || walk_state == WALK_DONE) return;
    if (consumed != 32'hFFFF_FFFF) consumed++;
    case (walk_state)
      WALK_PLAIN: begin
        plain_len = {plain_len[23:0], b};
        if (len_byte_idx == 2'd3) begin
          if (plain_len == 0) begin
            // end marker: valid needs a block and a nonzero sum within the limit
            ended = 1'b1;
            st = (nblocks != 0 && usum != 0 && usum <= cfg_max)
                 ? lbcw_pkg::ST_VALID : lbcw_pkg::ST_INVALID;
          end else begin
            walk_state = WALK_PACKED;
            pk_len = '0;
          end
        end
        len_byte_idx++;  // wraps to 0 after the 4th byte
      end
      WALK_PACKED: begin
        pk_len = {pk_len[23:0], b};
        if (len_byte_idx == 2'd3) begin
          skip_left = checksum_span(cfg_cksel, plain_len, pk_len);
          if (pk_len == 0 || pk_len > plain_len) begin
            ended = 1'b1;
          end else if (skip_left != 0) begin
            walk_state = WALK_CHECK;
          end else begin
            walk_state = WALK_PAYLOAD;
            skip_left = pk_len;
          end
        end
        len_byte_idx++;
      end
      WALK_CHECK: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          walk_state = WALK_PAYLOAD;
          skip_left = pk_len;
        end
      end
      default: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          sum_next = {1'b0, usum} + plain_len;
          usum = sum_next[48] ? {48{1'b1}} : sum_next[47:0];
          if (nblocks != 32'hFFFF_FFFF) nblocks++;
          walk_state = WALK_PLAIN;
          len_byte_idx = '0;
          plain_len = '0;
        end
      end
    endcase
    // source ran dry on a byte that did not close the walk itself
    if (l) ended = 1'b1;
    if (ended) begin
      got = 1'b1;
      walk_state = WALK_DONE;
      r.status = st;
      r.stream_length = consumed;
      r.block_count = nblocks;
      r.total_uncompressed = usum;
    end
  endtask

  // Offer one byte item, wait for the handshake, then predict it.
  task automatic send_byte(input logic [7:0] b, input logic f, l,
                           output bit got, output lbcw_pkg::result_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    walk_step(b, f, l, got, r);
  endtask

  task automatic feed(input logic [7:0] b, input logic f, l);
    bit                got;
    lbcw_pkg::result_t r;
    send_byte(b, f, l, got, r);
    if (got) expected_results.push_back(r);
  endtask

  // One walk: mostly well-formed chains with random content, some broken.
  task automatic random_walk();
    logic [7:0]  chain [$];
    logic [63:0] lengths;
    int unsigned n_blocks, plain, pk, flaw, stop_at, i;
    bit          broken, end_flag;
    chain = {};
    broken = 1'b0;
    n_blocks = $urandom_range(3);
    for (i = 0; i < n_blocks && !broken; i++) begin
      case ($urandom_range(19))
        0, 1:    plain = 32'hFFFF_FFFF;
        2, 3, 4: plain = $urandom_range(32'hFFFF_FFFF, 1);
        default: plain = $urandom_range(16, 1);
      endcase
      pk = $urandom_range((plain < 12) ? plain : 12, 1);
      if ($urandom_range(3) == 0 && plain <= 12) pk = plain;
      // bad compressed length: zero or above the uncompressed one
      if ($urandom_range(19) == 0) begin
        pk = ($urandom_range(1) == 0 || plain == 32'hFFFF_FFFF) ? 0 : plain + 1;
        broken = 1'b1;
      end
      lengths = {plain, pk};
      repeat (8) begin
        chain.push_back(lengths[63:56]);
        lengths = lengths << 8;
      end
      if (!broken)
        repeat (checksum_span(cfg_cksel, plain, pk) + pk)
          chain.push_back(8'($urandom_range(255)));
    end
    if (!broken) repeat (4) chain.push_back(8'h00);

    flaw = $urandom_range(99);
    stop_at = chain.size() - 1;
    end_flag = ($urandom_range(9) < 3);
    // cut the walk: with last set it runs dry, without it the next walk restarts it
    if (flaw < 18) begin
      stop_at = $urandom_range(chain.size() - 1);
      end_flag = (flaw < 12);
    end
    for (i = 0; i <= stop_at; i++) feed(chain[i], i == 0, end_flag && i == stop_at);
    items_in_phase += stop_at + 1;
    // stray bytes between walks
    if (flaw >= 18 && flaw < 28)
      repeat ($urandom_range(3, 1)) feed(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  // Config port write; the trailing wait keeps back-to-back writes clean.
  task automatic write_reg(input logic idx, input logic [47:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == lbcw_pkg::REG_CHECKSUM_SELECT) cfg_cksel = val[3:0];
    else cfg_max = val;
    @(posedge clk);
  endtask

  // Wait for every expected result, then idle before going on.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Receiver: random back-pressure, decided fresh every cycle.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Result checker: values seen here are the ones the DUT saw at this edge.
  always @(posedge clk) begin
    lbcw_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d length %0d",
                                  status, stream_length));
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (stream_length !== want.stream_length)
          report_mismatch($sformatf("stream_length %0d, expected %0d",
                                    stream_length, want.stream_length));
        if (block_count !== want.block_count)
          report_mismatch($sformatf("block_count %0d, expected %0d",
                                    block_count, want.block_count));
        if (total_uncompressed !== want.total_uncompressed)
          report_mismatch($sformatf("total_uncompressed %0d, expected %0d",
                                    total_uncompressed, want.total_uncompressed));
      end
    end
  end

  initial begin
    int unsigned       phase_idx;
    logic [3:0]        sel;
    logic [47:0]       limit;
    bit                got;
    lbcw_pkg::result_t r;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset config.
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].first_flag,
                directed_rows[i].last_flag, got, r);
      if (directed_rows[i].typed) expected_results.push_back(directed_rows[i].want);
      else if (got) expected_results.push_back(r);
    end
    drain_results();

    // Random phases: none idle, sender idle, receiver stalls, both a little.
    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      case (phase_idx)
        0: begin
          send_gap_pct = 0;  stall_pct = 0;
          sel = 4'h0;        limit = {48{1'b1}};
        end
        1: begin
          send_gap_pct = 71; stall_pct = 0;
          sel = 4'hF;        limit = 48'h0000_FFFF_FFFF;
        end
        2: begin
          send_gap_pct = 0;  stall_pct = 71;
          sel = 4'($urandom_range(15)); limit = '0;
        end
        default: begin
          send_gap_pct = 13; stall_pct = 13;
          sel = 4'($urandom_range(15)); limit = 48'($urandom_range(40));
        end
      endcase
      write_reg(lbcw_pkg::REG_CHECKSUM_SELECT, {44'd0, sel});
      write_reg(lbcw_pkg::REG_MAX_TOTAL, limit);
      items_in_phase = 0;

      while (items_in_phase < 110) random_walk();
      // one-byte walk that runs dry at once, so the block is idle for the next config
      feed(8'h00, 1'b1, 1'b1);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: a hang or a lost result ends here.
  initial begin
    #(30_000_000);
    $display("tb_top failed");
    $finish;
  end

endmodule
